[rtl/core/srl_pkg.sv]
package srl_pkg;

   // Characters of the record syntax
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_UPPER_S = 8'h53;
   localparam logic [7:0] CHAR_LOWER_S = 8'h73;
   localparam logic [7:0] CHAR_TYPE_0 = 8'h30;
   localparam logic [7:0] CHAR_TYPE_3 = 8'h33;
   localparam logic [7:0] CHAR_TYPE_7 = 8'h37;

   // Fixed record layout
   localparam logic [7:0] S3_OVERHEAD = 8'd5;
   localparam logic [7:0] SUM_GOOD    = 8'hff;
   localparam int         NAME_CHARS  = 12;
   localparam logic [3:0] NAME_MAX    = 4'd12;

   // Line verdict codes
   localparam logic [2:0] STATUS_ACK      = 3'd0;
   localparam logic [2:0] STATUS_FORMAT   = 3'd1;
   localparam logic [2:0] STATUS_COUNT    = 3'd2;
   localparam logic [2:0] STATUS_CHECKSUM = 3'd3;
   localparam logic [2:0] STATUS_TYPE     = 3'd4;
   localparam logic [2:0] STATUS_LONG     = 3'd5;

   // Result kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_NAME_LOW  = 2'd0;
   localparam logic [1:0] CSR_NAME_HIGH = 2'd1;
   localparam logic [1:0] CSR_NAME_LEN  = 2'd2;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_CHECK,
      SEQ_DATA_HI,
      SEQ_DATA_LO,
      SEQ_DATA_CAP,
      SEQ_DATA_OUT,
      SEQ_VERDICT
   } seq_type;

   typedef struct packed {
      logic [7:0] rx_char;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [7:0]  data_byte;
      logic [2:0]  status;
      logic        erase_request;
      logic        start_firmware;
      logic        last;
   } rsp_payload_type;

   // Decode one hex digit, either case; bit 4 flags a valid digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] u;
      logic [4:0] r;
      u = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         u = c - 8'h20;
      end
      r = 5'b0;
      if (u >= 8'h30 && u <= 8'h39) begin
         r = {1'b1, 4'(u - 8'h30)};
      end else if (u >= 8'h41 && u <= 8'h46) begin
         r = {1'b1, 4'(u - 8'h37)};
      end
      return r;
   endfunction

endpackage

[rtl/core/srl_stream_if.sv]
interface srl_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/srl_ram.sv]
module srl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry and read one entry; the read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/srecord_line_loader.sv]
// Channel   Direction  Payload
// req_chan  in         rx_char: one received character
// rsp_chan  out        kind, address, data_byte, status, erase_request, start_firmware, last
// csr_*     in         write-only name registers (index 0..2)
//
// A character is taken only while idle; a character that ends a line starts a walk
// over the stored line through the single line-buffer read port: one stored
// character per cycle for the check, then for each data byte of an S3 the steps
// high digit, low digit, capture and output.
// Reset is synchronous; the line buffer needs no clearing.
// A stalled result holds the data and verdict steps; no character is taken until the verdict is out.
module srecord_line_loader #(
   parameter int LINE_CHARS = 256,
   parameter int MAX_DATA   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   srl_stream_if.sink           req_chan,
   srl_stream_if.source         rsp_chan,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata
);
   import srl_pkg::*;

   localparam int CW = $clog2(LINE_CHARS);
   localparam int LW = (CW > 9) ? CW + 1 : 10;
   localparam logic [7:0] MaxData = 8'(MAX_DATA);

   seq_type state_ff, state_in;

   logic [63:0]   name_low_ff;
   logic [31:0]   name_high_ff;
   logic [3:0]    name_len_ff;

   logic [CW-1:0] char_count_ff;
   logic          prev_cr_ff;
   logic [CW-1:0] len_ff;
   logic [CW-1:0] issue_idx_ff;
   logic          proc_v_ff;
   logic [CW-1:0] proc_pos_ff;
   logic          first_ok_ff;
   logic [7:0]    type_ff;
   logic [3:0]    hi_ff;
   logic          hi_ok_ff;
   logic [7:0]    sum_ff;
   logic [7:0]    count_ff;
   logic [31:0]   addr_ff;
   logic          addr_bad_ff;
   logic [3:0]    name_i_ff;
   logic          name_bad_ff;
   logic [2:0]    v_status_ff;
   logic          v_erase_ff;
   logic          v_start_ff;
   logic [CW-1:0] dptr_ff;
   logic [7:0]    di_ff;
   logic [7:0]    nd_ff;
   logic [7:0]    dbyte_ff;
   logic          rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic          req_take;
   logic [7:0]    rx_c;
   logic [CW:0]   next_count;
   logic          line_drop;
   logic          line_end;
   logic [CW-1:0] line_len;
   logic          line_start;

   logic [CW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          issue;
   logic          out_free;
   logic          load_data;
   logic          load_verdict;

   logic [4:0]    nib;
   logic          pair_ok;
   logic [7:0]    pair_byte;
   logic [CW-2:0] pair_j;
   logic          is_last;
   logic [3:0]    name_lim;
   logic [7:0]    name_arr [NAME_CHARS];
   logic [7:0]    name_c;

   logic [LW-1:0] len_ext;
   logic [LW-1:0] cnt2_ext;
   logic [7:0]    ndata;
   logic [2:0]    chk_status;
   logic          chk_erase;
   logic          chk_start;
   logic          chk_data;

   // Line buffer
   srl_ram #(
      .WIDTH (8),
      .DEPTH (LINE_CHARS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (char_count_ff),
      .wr_data (rx_c),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Character intake
   assign rx_c       = req_chan.payload.rx_char;
   assign req_take   = req_chan.valid && req_chan.ready;
   assign next_count = {1'b0, char_count_ff} + 1'b1;
   assign line_drop  = next_count >= (CW+1)'(LINE_CHARS);
   assign line_end   = !line_drop && (rx_c == CHAR_LF);
   assign line_len   = char_count_ff - CW'(((char_count_ff != '0) && prev_cr_ff) ? 1 : 0);
   assign line_start = req_take && line_end && (line_len != '0);

   // Per-character decode for the walk
   assign nib       = hex_nibble(rd_data);
   assign pair_ok   = hi_ok_ff && nib[4];
   assign pair_byte = pair_ok ? {hi_ff, nib[3:0]} : 8'h00;
   assign pair_j    = proc_pos_ff[CW-1:1] - 1'b1;
   assign is_last   = proc_pos_ff == (len_ff - 1'b1);
   assign name_lim  = (name_len_ff > NAME_MAX) ? NAME_MAX : name_len_ff;

   always_comb begin
      for (int k = 0; k < NAME_CHARS; k++) begin
         name_arr[k] = (k < 8) ? name_low_ff[8*k +: 8] : name_high_ff[8*(k-8) +: 8];
      end
   end
   assign name_c = (name_i_ff < NAME_MAX) ? name_arr[name_i_ff] : 8'h00;

   // Line verdict
   assign len_ext  = LW'(len_ff);
   assign cnt2_ext = LW'({count_ff, 1'b0});
   assign ndata    = count_ff - S3_OVERHEAD;

   always_comb begin
      chk_status = STATUS_ACK;
      chk_erase  = 1'b0;
      chk_start  = 1'b0;
      chk_data   = 1'b0;
      priority if (!first_ok_ff || len_ff[0]) begin
         chk_status = STATUS_FORMAT;
      end else if (len_ff < CW'(4) || cnt2_ext != len_ext - LW'(4)) begin
         chk_status = STATUS_COUNT;
      end else if (sum_ff != SUM_GOOD) begin
         chk_status = STATUS_CHECKSUM;
      end else if (type_ff == CHAR_TYPE_0) begin
         chk_erase = (name_lim != '0) && !name_bad_ff && (name_i_ff >= name_lim);
      end else if (type_ff == CHAR_TYPE_3) begin
         if (count_ff >= S3_OVERHEAD) begin
            if (ndata > MaxData) begin
               chk_status = STATUS_LONG;
            end else begin
               chk_data = ndata != 8'd0;
            end
         end
      end else if (type_ff == CHAR_TYPE_7) begin
         chk_start = 1'b1;
      end else begin
         chk_status = STATUS_TYPE;
      end
   end

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE:     if (line_start) state_in = SEQ_SCAN;
         SEQ_SCAN:     if (proc_v_ff && is_last) state_in = SEQ_CHECK;
         SEQ_CHECK:    state_in = chk_data ? SEQ_DATA_HI : SEQ_VERDICT;
         SEQ_DATA_HI:  state_in = SEQ_DATA_LO;
         SEQ_DATA_LO:  state_in = SEQ_DATA_CAP;
         SEQ_DATA_CAP: state_in = SEQ_DATA_OUT;
         SEQ_DATA_OUT: begin
            if (out_free) begin
               state_in = (di_ff == nd_ff - 1'b1) ? SEQ_VERDICT : SEQ_DATA_HI;
            end
         end
         SEQ_VERDICT:  if (out_free) state_in = SEQ_IDLE;
         default:      state_in = SEQ_IDLE;
      endcase
   end

   // Sequencer: outputs
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      req_chan.ready = 1'b0;
      rd_addr        = issue_idx_ff;
      issue          = 1'b0;
      load_data      = 1'b0;
      load_verdict   = 1'b0;
      unique case (state_ff)
         SEQ_IDLE:     req_chan.ready = 1'b1;
         SEQ_SCAN:     issue = issue_idx_ff < len_ff;
         SEQ_DATA_HI,
         SEQ_DATA_LO:  rd_addr = dptr_ff;
         SEQ_DATA_OUT: load_data = out_free;
         SEQ_VERDICT:  load_verdict = out_free;
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Name registers
   always_ff @(posedge clock) begin
      if (reset) begin
         name_low_ff  <= '0;
         name_high_ff <= '0;
         name_len_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NAME_LOW:  name_low_ff  <= csr_wdata;
            CSR_NAME_HIGH: name_high_ff <= csr_wdata[31:0];
            CSR_NAME_LEN:  name_len_ff  <= csr_wdata[3:0];
            default:       ;
         endcase
      end
   end

   // Line assembly
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         prev_cr_ff    <= 1'b0;
      end else if (req_take) begin
         prev_cr_ff <= rx_c == CHAR_CR;
         if (line_drop || line_end) begin
            char_count_ff <= '0;
         end else begin
            char_count_ff <= next_count[CW-1:0];
         end
      end
   end

   // Walk datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         proc_v_ff <= 1'b0;
      end else begin
         proc_v_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         SEQ_IDLE: begin
            len_ff       <= line_len;
            issue_idx_ff <= '0;
            first_ok_ff  <= 1'b0;
            sum_ff       <= '0;
            count_ff     <= '0;
            addr_ff      <= '0;
            addr_bad_ff  <= 1'b0;
            name_i_ff    <= '0;
            name_bad_ff  <= 1'b0;
         end
         SEQ_SCAN: begin
            if (issue) begin
               issue_idx_ff <= issue_idx_ff + 1'b1;
            end
            proc_pos_ff <= issue_idx_ff;
            if (proc_v_ff) begin
               if (proc_pos_ff == CW'(0)) begin
                  first_ok_ff <= (rd_data == CHAR_UPPER_S) || (rd_data == CHAR_LOWER_S);
               end else if (proc_pos_ff == CW'(1)) begin
                  type_ff <= rd_data;
               end else if (!proc_pos_ff[0]) begin
                  hi_ff    <= nib[3:0];
                  hi_ok_ff <= nib[4];
               end else begin
                  // Fold one complete byte pair
                  sum_ff <= sum_ff + pair_byte;
                  if (pair_j == '0) begin
                     count_ff <= pair_byte;
                  end
                  if (pair_j >= (CW-1)'(1) && pair_j <= (CW-1)'(4)) begin
                     addr_ff     <= {addr_ff[23:0], pair_byte};
                     addr_bad_ff <= addr_bad_ff || !pair_ok;
                  end
                  if (pair_j >= (CW-1)'(3) && !is_last) begin
                     if (name_i_ff < name_lim) begin
                        if (pair_byte != name_c || pair_byte == 8'h00) begin
                           name_bad_ff <= 1'b1;
                        end
                     end else if (name_i_ff == name_lim && pair_byte != 8'h00) begin
                        name_bad_ff <= 1'b1;
                     end
                     if (name_i_ff != 4'hf) begin
                        name_i_ff <= name_i_ff + 1'b1;
                     end
                  end
               end
            end
         end
         SEQ_CHECK: begin
            v_status_ff <= chk_status;
            v_erase_ff  <= chk_erase;
            v_start_ff  <= chk_start;
            dptr_ff     <= CW'(12);
            di_ff       <= '0;
            nd_ff       <= ndata;
            if (addr_bad_ff) begin
               addr_ff <= '0;
            end
         end
         SEQ_DATA_HI: dptr_ff <= dptr_ff + 1'b1;
         SEQ_DATA_LO: begin
            dptr_ff  <= dptr_ff + 1'b1;
            hi_ff    <= nib[3:0];
            hi_ok_ff <= nib[4];
         end
         SEQ_DATA_CAP: dbyte_ff <= pair_byte;
         SEQ_DATA_OUT: begin
            if (load_data) begin
               addr_ff <= addr_ff + 32'd1;
               di_ff   <= di_ff + 8'd1;
            end
         end
         default: ;
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_data || load_verdict) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_data) begin
         rsp_data_ff.kind           <= KIND_DATA;
         rsp_data_ff.address        <= addr_ff;
         rsp_data_ff.data_byte      <= dbyte_ff;
         rsp_data_ff.status         <= STATUS_ACK;
         rsp_data_ff.erase_request  <= 1'b0;
         rsp_data_ff.start_firmware <= 1'b0;
         rsp_data_ff.last           <= 1'b0;
      end else if (load_verdict) begin
         rsp_data_ff.kind           <= KIND_VERDICT;
         rsp_data_ff.address        <= '0;
         rsp_data_ff.data_byte      <= '0;
         rsp_data_ff.status         <= v_status_ff;
         rsp_data_ff.erase_request  <= v_erase_ff;
         rsp_data_ff.start_firmware <= v_start_ff;
         rsp_data_ff.last           <= 1'b1;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Checks
   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == KIND_DATA |->
         !rsp_data_ff.last && rsp_data_ff.status == STATUS_ACK)
      else $error("data result marked as verdict");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.erase_request && rsp_data_ff.start_firmware))
      else $error("erase and start raised together");

   a_data_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_DATA_OUT |-> di_ff < nd_ff && nd_ff <= MaxData)
      else $error("data index past record length");

   a_verdict_ends: assert property (@(posedge clock) disable iff (reset)
      load_verdict |=> state_ff == SEQ_IDLE && rsp_valid_ff && rsp_data_ff.last)
      else $error("verdict did not close the line");
endmodule

[bench/testbench.sv]
module testbench;
   import srl_pkg::*;

   localparam int LINE_CHARS = 256;
   localparam int MAX_DATA   = 32;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_NAME_LOW;
   logic [63:0] csr_wdata = '0;

   srl_stream_if #(.payload_type(req_payload_type)) req_chan ();
   srl_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   srecord_line_loader #(.LINE_CHARS(LINE_CHARS), .MAX_DATA(MAX_DATA)) i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // loader model state
   logic [7:0]  line_buf [LINE_CHARS];
   int unsigned line_fill;
   logic [63:0] name_low;
   logic [31:0] name_high;
   logic [3:0]  name_len;

   rsp_payload_type expected_rsp [$];
   int unsigned error_count;
   int unsigned rsp_count;
   int unsigned char_count;
   int unsigned line_count;
   bit          rsp_stall_on;

   task automatic report(input string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   function automatic int hex_digit(input logic [7:0] c);
      logic [7:0] u;
      u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
      if (u >= "0" && u <= "9") return u - "0";
      if (u >= "A" && u <= "F") return u - "A" + 10;
      return -1;
   endfunction

   // decode a hex field, zero if any digit is bad or past the end
   function automatic logic [31:0] field_at(input int pos, input int ndig, input int len);
      logic [31:0] v;
      int d;
      v = '0;
      for (int i = 0; i < ndig; i++) begin
         if (pos + i >= len) return '0;
         d = hex_digit(line_buf[pos + i]);
         if (d < 0) return '0;
         v = (v << 4) | d[3:0];
      end
      return v;
   endfunction

   function automatic logic [7:0] name_char(input int k);
      if (k < 8) return name_low[8*k +: 8];
      return name_high[8*(k-8) +: 8];
   endfunction

   function automatic void push_rsp(input logic kind, input logic [31:0] addr,
                                    input logic [7:0] data, input logic [2:0] status,
                                    input logic erase, input logic start);
      rsp_payload_type r;
      r.kind = kind; r.address = addr; r.data_byte = data; r.status = status;
      r.erase_request = erase; r.start_firmware = start; r.last = kind;
      expected_rsp.push_back(r);
   endfunction

   function automatic void judge_line(input int len);
      logic [31:0] count, sum, addr;
      int nbytes, nl, slen;
      bit match;
      if ((line_buf[0] != CHAR_UPPER_S && line_buf[0] != CHAR_LOWER_S) || len[0]) begin
         push_rsp(KIND_VERDICT, 0, 0, STATUS_FORMAT, 0, 0); return;
      end
      count = field_at(2, 2, len);
      if (len < 4 || count * 2 != len - 4) begin
         push_rsp(KIND_VERDICT, 0, 0, STATUS_COUNT, 0, 0); return;
      end
      sum = 0;
      for (int p = 2; p < len; p += 2) sum += field_at(p, 2, len);
      if (sum[7:0] != SUM_GOOD) begin
         push_rsp(KIND_VERDICT, 0, 0, STATUS_CHECKSUM, 0, 0); return;
      end
      if (line_buf[1] == CHAR_TYPE_0) begin
         nbytes = (len > 10) ? (len - 10) / 2 : 0;
         nl = (name_len > NAME_MAX) ? NAME_CHARS : int'(name_len);
         slen = nbytes;
         for (int i = 0; i < nbytes; i++)
            if (field_at(8 + 2*i, 2, len) == 0) begin slen = i; break; end
         match = (nl != 0) && (slen == nl);
         for (int i = 0; match && i < nl; i++)
            if (field_at(8 + 2*i, 2, len) != name_char(i)) match = 0;
         push_rsp(KIND_VERDICT, 0, 0, STATUS_ACK, match, 0);
      end else if (line_buf[1] == CHAR_TYPE_3) begin
         if (count < S3_OVERHEAD) begin
            push_rsp(KIND_VERDICT, 0, 0, STATUS_ACK, 0, 0); return;
         end
         if (count - S3_OVERHEAD > MAX_DATA) begin
            push_rsp(KIND_VERDICT, 0, 0, STATUS_LONG, 0, 0); return;
         end
         addr = field_at(4, 8, len);
         for (int i = 0; i < count - S3_OVERHEAD; i++)
            push_rsp(KIND_DATA, addr + i, 8'(field_at(12 + 2*i, 2, len)),
                     STATUS_ACK, 0, 0);
         push_rsp(KIND_VERDICT, 0, 0, STATUS_ACK, 0, 0);
      end else if (line_buf[1] == CHAR_TYPE_7) begin
         push_rsp(KIND_VERDICT, 0, 0, STATUS_ACK, 0, 1);
      end else begin
         push_rsp(KIND_VERDICT, 0, 0, STATUS_TYPE, 0, 0);
      end
   endfunction

   // advance the model by one received character
   function automatic void take_char(input logic [7:0] c);
      int pos, len;
      pos = (line_fill >= LINE_CHARS) ? 0 : line_fill;
      line_buf[pos] = c;
      line_fill = pos + 1;
      if (line_fill >= LINE_CHARS) begin line_fill = 0; return; end
      if (c != CHAR_LF) return;
      line_fill = 0;
      len = pos;
      if (len >= 1 && line_buf[len-1] == CHAR_CR) len--;
      if (len == 0) return;
      line_count++;
      judge_line(len);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // send one character and wait for its transfer; valid stays up until the
   // next character, a gap or wait_idle drops it
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = gap_len();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload.rx_char <= c;
      do @(posedge clock); while (!req_chan.ready);
      take_char(c);
      char_count++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // build a record: type char, body bytes; count and checksum computed
   task automatic send_record(input logic [7:0] type_ch, input logic [7:0] body [$],
                              input bit lower, input bit crlf, input bit bad_sum);
      logic [7:0] count, sum;
      string s;
      count = 8'(body.size() + 1);
      sum = count;
      foreach (body[i]) sum += body[i];
      sum = ~sum;
      if (bad_sum) sum ^= 8'h01;
      s = $sformatf("%s%c%02X", lower ? "s" : "S", type_ch, count);
      foreach (body[i]) s = {s, lower ? $sformatf("%02x", body[i]) : $sformatf("%02X", body[i])};
      s = {s, $sformatf("%02X", sum), crlf ? "\r\n" : "\n"};
      send_text(s);
   endtask

   task automatic send_s3(input logic [31:0] addr, input int n, input bit bad_sum);
      logic [7:0] body [$];
      for (int i = 0; i < 4; i++) body.push_back(addr[31 - 8*i -: 8]);
      for (int i = 0; i < n; i++) body.push_back(8'($urandom()));
      send_record(CHAR_TYPE_3, body, $urandom_range(0, 3) == 0, $urandom_range(0, 1) != 0,
                  bad_sum);
   endtask

   task automatic send_s0(input string name, input bit pad_zero);
      logic [7:0] body [$];
      body = {8'h00, 8'h00};
      for (int i = 0; i < name.len(); i++) body.push_back(name[i]);
      if (pad_zero) begin
         body.push_back(8'h00);
         body.push_back(8'($urandom_range(1, 255)));
      end
      send_record(CHAR_TYPE_0, body, 0, 1, 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_NAME_LOW:  name_low = val;
         CSR_NAME_HIGH: name_high = val[31:0];
         default:       name_len = val[3:0];
      endcase
   endtask

   // drop the request, drain outstanding results, then let the walk settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_name(input string name, input logic [3:0] len_val);
      logic [63:0] lo;
      logic [31:0] hi;
      lo = '0; hi = '0;
      for (int i = 0; i < name.len() && i < 12; i++)
         if (i < 8) lo[8*i +: 8] = name[i]; else hi[8*(i-8) +: 8] = name[i];
      wait_idle();
      write_csr(CSR_NAME_LOW, lo);
      write_csr(CSR_NAME_HIGH, {32'h0, hi});
      write_csr(CSR_NAME_LEN, {60'h0, len_val});
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         rsp_count++;
         if (expected_rsp.size() == 0) begin
            report($sformatf("unexpected result kind=%0d status=%0d", got.kind, got.status));
         end else begin
            want = expected_rsp.pop_front();
            if (got.kind !== want.kind) report("kind differs");
            if (got.address !== want.address)
               report($sformatf("address %h, want %h", got.address, want.address));
            if (got.data_byte !== want.data_byte)
               report($sformatf("data %h, want %h", got.data_byte, want.data_byte));
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.erase_request !== want.erase_request) report("erase_request differs");
            if (got.start_firmware !== want.start_firmware) report("start_firmware differs");
            if (got.last !== want.last) report("last differs");
         end
      end
   end

   // randomly stall the result side
   always @(negedge clock) begin
      if (!rsp_stall_on) rsp_chan.ready <= 1'b1;
      else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
   end

   task automatic test_directed();
      logic [7:0] body [$];
      set_name("BOOTIMAGE.BIN", 4'd13);
      send_s3(32'h0000_0000, 0, 0);
      send_s3(32'hffff_fffe, 4, 0);
      send_s3(32'h1234_5678, MAX_DATA, 0);
      send_s3(32'h0000_1000, MAX_DATA + 1, 0);
      send_s3(32'h0000_2000, 3, 1);
      send_text("S30300FC\n");
      send_s0("BOOTIMAGE.BIN", 0);
      send_s0("BOOTIMAGE.BI", 1);
      send_s0("OTHER", 0);
      body = {8'h00, 8'h00, 8'h00, 8'h00};
      send_record(CHAR_TYPE_7, body, 0, 1, 0);
      send_record("9", body, 0, 0, 0);
      send_text("X1030000FC\n");
      send_text("S10300F\n");
      send_text("S1\r\n");
      send_text("S3050000000\n");
      send_text("S3XY00000000ZZ\n");
      send_text("\n\r\n");
      send_text("s30600000000g0F9\n");
      send_text("S\n");
      // overlong line with no LF is dropped
      for (int i = 0; i < LINE_CHARS + 5; i++) send_char(8'(8'h41 + i % 20));
      send_text("\n");
      send_char(8'hff); send_char(8'h80); send_text("\n");
   endtask

   task automatic test_random();
      int pick;
      string nm;
      nm = "";
      for (int i = 0; i < 5; i++) nm = {nm, string'(8'(8'h41 + $urandom_range(0, 25)))};
      set_name(nm, 4'd5);
      while (char_count < 1100) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) send_s3($urandom(), ($urandom_range(0, 9) == 0) ?
                                $urandom_range(0, MAX_DATA + 3) : $urandom_range(0, 6),
                                $urandom_range(0, 9) == 0);
         else if (pick < 65) send_s0($urandom_range(0, 1) ? nm : "ZZ",
                                     $urandom_range(0, 1) != 0);
         else if (pick < 72) begin
            automatic logic [7:0] b [$] = {8'($urandom()), 8'($urandom()),
                                           8'($urandom()), 8'($urandom())};
            send_record(($urandom_range(0, 1) ? CHAR_TYPE_7 : 8'h31), b, 0, 1,
                        $urandom_range(0, 5) == 0);
         end else begin
            // noise: random characters, sometimes ending the line
            repeat ($urandom_range(1, 12)) send_char(8'($urandom()));
            if ($urandom_range(0, 1)) send_char(CHAR_LF);
         end
      end
   endtask

   task automatic test_config_extremes();
      set_name("", 4'd0);
      send_s0("", 0);
      set_name("ABCDEFGHIJKL", 4'd15);
      send_s0("ABCDEFGHIJKL", 0);
      set_name("Q", 4'd1);
      send_s0("Q", 0);
      wait_idle();
      write_csr(CSR_NAME_LOW, 64'hffff_ffff_ffff_ffff);
      write_csr(CSR_NAME_HIGH, 64'hffff_ffff);
      write_csr(CSR_NAME_LEN, 64'd12);
      send_s0(string'({12{8'hff}}), 0);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_stall_on = 1'b0;
      name_low = '0; name_high = '0; name_len = '0;
      line_fill = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      rsp_stall_on = 1'b1;
      test_config_extremes();
      test_random();
      rsp_stall_on = 1'b0;
      wait_idle();
      $display("Sent %0d characters in %0d checked lines; %0d results compared.",
               char_count, line_count, rsp_count);
      if (error_count == 0 && expected_rsp.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout: %0d results still expected", expected_rsp.size());
      $display("Some tests failed");
      $finish;
   end
endmodule
